// File: rtl/assert_macros.svh
// Assertion macros used by the checker module of the matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SWPM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define SWPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/swpm_pkg.sv
// Package of the swap-tolerant pattern matcher: sizes, command codes and cell link types.
package swpm_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int LEN_W       = 7;
	localparam int IDX_W       = 6;
	localparam int LETTER_W    = 5;
	localparam int CMD_W       = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_TEXT  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		logic                text_en;
		logic                clear_en;
		logic [LETTER_W-1:0] letter;
	} swpm_ctl_t;

	typedef struct packed {
		logic done;
		logic first;
		logic eq;
	} swpm_link_t;

	localparam swpm_link_t LINK_HEAD = '{done: 1'b1, first: 1'b0, eq: 1'b0};
	localparam swpm_link_t LINK_TAIL = '{done: 1'b0, first: 1'b0, eq: 1'b0};

endpackage

// File: rtl/swpm_cell.sv
// One pattern position: stored letter and its plain, swap-first and swap-second match bits.
module swpm_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swpm_pkg::swpm_ctl_t  ctl,
	input  logic                 wr_en,
	input  logic                 active,
	input  logic                 right_active,
	input  swpm_pkg::swpm_link_t left,
	input  swpm_pkg::swpm_link_t right,
	output swpm_pkg::swpm_link_t link,
	output logic                 done_next
);
	import swpm_pkg::*;

	logic [LETTER_W-1:0] letter_q;
	logic                plain_q;
	logic                first_q;
	logic                second_q;
	logic                eq;
	logic                plain_d;
	logic                first_d;
	logic                second_d;

	assign eq       = (letter_q == ctl.letter);
	assign plain_d  = active & left.done & eq;
	assign first_d  = right_active & left.done & right.eq;
	assign second_d = active & left.first & left.eq;

	assign done_next = plain_d | second_d;
	assign link      = '{done: plain_q | second_q, first: first_q, eq: eq};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			letter_q <= ctl.letter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain_q  <= 1'b0;
			first_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (ctl.clear_en) begin
			plain_q  <= 1'b0;
			first_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (ctl.text_en) begin
			plain_q  <= plain_d;
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

endmodule

// File: rtl/swap_tolerant_pattern_match.sv
// Top level of the swap-tolerant pattern matcher: cell chain, length mask and output skid.
//
// Shift-And matcher that tolerates disjoint adjacent swaps in a pattern of up to 64 letters.
// Every beat gives exactly one result beat: load (command 0) writes a pattern letter at
// pattern_index, text (command 1) advances all 64 cells at once and reports on match whether
// the pattern, with swaps, ends at this letter, clear (command 2) starts a new text; load,
// clear and the unused code give match 0. One beat is taken every cycle while the skid
// stage is empty: the cell row updates at once and each result is registered, with a
// one-entry skid stage so that a beat is still taken while one result waits. Write the
// length through cfg_we/cfg_wdata only while idle; 0 acts as 1 and values above 64 act as
// 64. Pattern positions below the length must be loaded first.
module swap_tolerant_pattern_match (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swpm_pkg::LEN_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [swpm_pkg::CMD_W-1:0]    command,
	input  logic [swpm_pkg::IDX_W-1:0]    pattern_index,
	input  logic [swpm_pkg::LETTER_W-1:0] letter,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          match
);
	import swpm_pkg::*;

	logic [LEN_W-1:0]       used_len;
	logic [MAX_PATTERN-1:0] active_d;
	logic [MAX_PATTERN-1:0] last_d;
	logic [MAX_PATTERN-1:0] active_q;
	logic [MAX_PATTERN-1:0] last_q;
	logic [MAX_PATTERN-1:0] wr_en;
	logic [MAX_PATTERN-1:0] done_next;
	swpm_link_t             link [MAX_PATTERN];
	swpm_ctl_t              ctl;
	logic                   accept;
	logic                   load_en;
	logic                   result;
	logic                   out_match_q;
	logic                   out_valid_q;
	logic                   skid_match_q;
	logic                   skid_valid_q;

	always_comb begin
		if (cfg_wdata == '0) begin
			used_len = LEN_W'(1);
		end else if (cfg_wdata > LEN_W'(MAX_PATTERN)) begin
			used_len = LEN_W'(MAX_PATTERN);
		end else begin
			used_len = cfg_wdata;
		end
		for (int j = 0; j < MAX_PATTERN; j++) begin
			active_d[j] = (LEN_W'(j) < used_len);
			last_d[j]   = (LEN_W'(j) == used_len - LEN_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= MAX_PATTERN'(1);
			last_q   <= MAX_PATTERN'(1);
		end else if (cfg_we) begin
			active_q <= active_d;
			last_q   <= last_d;
		end
	end

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign load_en  = accept && (command == CMD_LOAD);

	assign ctl.text_en  = accept && (command == CMD_TEXT);
	assign ctl.clear_en = accept && (command == CMD_CLEAR);
	assign ctl.letter   = letter;

	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			wr_en[j] = load_en && ({1'b0, pattern_index} < LEN_W'(MAX_PATTERN))
				&& (pattern_index == IDX_W'(j));
		end
	end

	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
		swpm_link_t left_link;
		swpm_link_t right_link;
		logic       right_act;

		if (g == 0) begin : g_head
			assign left_link = LINK_HEAD;
		end else begin : g_mid_left
			assign left_link = link[g-1];
		end

		if (g == MAX_PATTERN - 1) begin : g_tail
			assign right_link = LINK_TAIL;
			assign right_act  = 1'b0;
		end else begin : g_mid_right
			assign right_link = link[g+1];
			assign right_act  = active_q[g+1];
		end

		swpm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.wr_en        (wr_en[g]),
			.active       (active_q[g]),
			.right_active (right_act),
			.left         (left_link),
			.right        (right_link),
			.link         (link[g]),
			.done_next    (done_next[g])
		);
	end

	assign result = (command == CMD_TEXT) && (|(last_q & done_next));

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_match_q <= skid_valid_q ? skid_match_q : result;
		end else if (accept) begin
			skid_match_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign match     = out_match_q;

endmodule

// File: rtl/swpm_checker.sv
// Port-level checker of the swap-tolerant pattern matcher and its bind to the top level.
`include "assert_macros.svh"

module swpm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [swpm_pkg::CMD_W-1:0] command,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       match
);
	import swpm_pkg::*;

	`SWPM_ASSERT(a_ready_low_only_with_result, !in_ready |-> out_valid, "ready low with no result")
	`SWPM_ASSERT_NEXT(a_result_follows_beat, in_valid && in_ready && !out_valid, out_valid, "result missing")
	`SWPM_ASSERT_NEXT(a_no_match_off_text, in_valid && in_ready && !out_valid && command != CMD_TEXT, !match, "match on non-text beat")
	`SWPM_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(match), "stalled result changed")

endmodule

bind swap_tolerant_pattern_match swpm_checker u_checker (.*);
